### hdl/fsa_pkg.sv
// Shared constants, codes and helper functions of the frame stack allocator.
`default_nettype none

package fsa_pkg;

  // Most frames that may be open at once.
  localparam int unsigned MaxFrames = 255;
  // Frame counter width: it must hold MaxFrames itself.
  localparam int unsigned FrameW = $clog2(MaxFrames + 1);
  // Address width of the saved-top memory.
  localparam int unsigned AddrW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  // Width of byte offsets inside the buffer.
  localparam int unsigned OfsW = 16;
  // Width of the request size field.
  localparam int unsigned SizeW = 16;
  // Width of the space-needed sum: rounded size plus header.
  localparam int unsigned NeedW = SizeW + 2;
  // Width used to compare the top against the header bytes.
  localparam int unsigned CmpW = (OfsW > FrameW + 2) ? OfsW : FrameW + 2;

  // Capacity after reset, and header bytes per frame.
  localparam logic [15:0] CapacityReset = 16'd4096;
  localparam int unsigned HdrBytes = 4;

  // Register index decoded from the configuration address.
  localparam logic RegCapacity = 1'b0;

  typedef enum logic [1:0] {
    CMD_QUERY   = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_NO_ROOM = 2'd1,
    STS_EMPTY   = 2'd2,
    STS_LIMIT   = 2'd3
  } status_e;

  // Usable top of the buffer: the capacity rounded down to eight.
  function automatic logic [OfsW-1:0] usable_top(input logic [15:0] cap);
    logic [OfsW-1:0] c;
    c = OfsW'(cap);
    return {c[OfsW-1:3], 3'b000};
  endfunction

  // Free bytes between the headers and the data, floored at zero.
  function automatic logic [OfsW-1:0] free_bytes(input logic [OfsW-1:0]   top,
                                                 input logic [FrameW-1:0] frames);
    logic [CmpW-1:0] t;
    logic [CmpW-1:0] h;
    t = CmpW'(top);
    h = CmpW'({frames, 2'b00});
    return (t >= h) ? OfsW'(t - h) : '0;
  endfunction

endpackage

`default_nettype wire

### hdl/fsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fsa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire                             clk_i,
  input  wire                             we_i,
  input  wire [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  wire [Width-1:0]                 wdata_i,
  input  wire [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port, and a read that returns the old contents on a collision.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/frame_stack_allocator_core.sv
// Top level of the frame stack allocator: command stream in, result stream out.
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: request_size
//  m_axis   | out       | tdata: status, can_fit, block_offset, remaining,
//           |           |        frame_count
//  apb      | in        | capacity register at byte address 0
//
// An item is accepted and its saved-top entry is read from the registered memory
// port in that cycle; the result is then computed and written to the output
// register once the output is free. A new item is taken in the cycle the result
// is written, so one item per cycle is sustained while the output is taken; the
// registered memory read with a bypass on a same-entry write makes that rate
// possible. Reset is asynchronous and needs no clearing pass. When the output is
// held, the item in work waits and input stops.
`default_nettype none

module frame_stack_allocator_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Command stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [15:0] request_size
  input  wire  [1:0]  s_axis_tuser,   // [1:0] command
  // Result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [1:0] status, [2] can_fit,
                                      // [18:3] block_offset, [34:19] remaining,
                                      // [42:35] frame_count, rest zero
  // Configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import fsa_pkg::*;

  // Configuration and stack state
  logic [15:0]       cap_q;
  logic [OfsW-1:0]   top_q, top_d;
  logic [FrameW-1:0] frames_q, frames_d;

  // Item in work
  logic              exec_q;
  cmd_e              cmd_q;
  logic [SizeW-1:0]  size_q;
  logic              fwd_q;
  logic [OfsW-1:0]   fwd_data_q;

  // Output register
  logic              m_valid_q;
  logic [47:0]       m_data_q;

  // Handshakes
  logic              accept;
  logic              exec_done;
  logic              cfg_wr;

  // Memory ports
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [AddrW-1:0]  mem_raddr;
  logic [OfsW-1:0]   mem_rdata;
  logic [OfsW-1:0]   saved_top;
  logic [FrameW-1:0] frames_next;

  // Datapath
  logic [OfsW-1:0]   free_now;
  logic [SizeW:0]    aligned;
  logic [NeedW-1:0]  need;
  logic              fits;
  status_e           status;
  logic              can_fit;
  logic [OfsW-1:0]   free_after;

  assign exec_done     = exec_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !exec_q || exec_done;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Configuration port: writes on the access cycle, reads return the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegCapacity) ? {16'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
    end else if (cfg_wr && paddr[2] == RegCapacity) begin
      cap_q <= pwdata[15:0];
    end
  end

  // The entry of the last open frame is read for the next item.
  assign frames_next = exec_done ? frames_d : frames_q;
  assign mem_raddr   = (frames_next == '0) ? '0 : AddrW'(frames_next - FrameW'(1));

  fsa_ram #(
    .Width (OfsW),
    .Depth (MaxFrames)
  ) u_saved_tops (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (top_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Bypass a write that lands on the entry read in the same cycle.
  assign saved_top = fwd_q ? fwd_data_q : mem_rdata;

  // Fit check against the state before this item.
  assign free_now = free_bytes(top_q, frames_q);
  assign aligned  = ({1'b0, size_q} + (SizeW + 1)'(7)) & ~(SizeW + 1)'(7);
  assign need     = NeedW'(aligned) + NeedW'(HdrBytes);
  assign fits     = need <= NeedW'(free_now);

  // Command decode and next state.
  always_comb begin
    status    = STS_DONE;
    can_fit   = 1'b0;
    top_d     = top_q;
    frames_d  = frames_q;
    mem_we    = 1'b0;
    mem_waddr = AddrW'(frames_q);
    case (cmd_q)
      CMD_QUERY: begin
        can_fit = fits;
      end
      CMD_ALLOC: begin
        can_fit = fits;
        if (frames_q >= FrameW'(MaxFrames)) begin
          status = STS_LIMIT;
        end else if (!fits) begin
          status = STS_NO_ROOM;
        end else begin
          mem_we   = exec_done;
          top_d    = top_q - OfsW'(aligned);
          frames_d = frames_q + FrameW'(1);
        end
      end
      CMD_RELEASE: begin
        if (frames_q == '0) begin
          status = STS_EMPTY;
        end else begin
          top_d    = saved_top;
          frames_d = frames_q - FrameW'(1);
        end
      end
      CMD_CLEAR: begin
        top_d    = usable_top(cap_q);
        frames_d = '0;
      end
      default: begin
        status = STS_DONE;
      end
    endcase
  end

  assign free_after = free_bytes(top_d, frames_d);

  // Stack state and the item in work.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= usable_top(CapacityReset);
      frames_q <= '0;
      exec_q   <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (exec_done) begin
        top_q    <= top_d;
        frames_q <= frames_d;
      end
      if (accept) begin
        exec_q <= 1'b1;
        fwd_q  <= mem_we && (mem_waddr == mem_raddr);
      end else if (exec_done) begin
        exec_q <= 1'b0;
        fwd_q  <= 1'b0;
      end
    end
  end

  // Item payload and bypass data.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_e'(s_axis_tuser);
      size_q     <= s_axis_tdata;
      fwd_data_q <= top_q;
    end
  end

  // Output register: loaded when the item finishes, emptied when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (exec_done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_done) begin
      m_data_q <= {5'd0, 8'(frames_d), 16'(free_after), 16'(top_d), can_fit, status};
    end
  end

  // The frame count never passes the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q <= FrameW'(MaxFrames))
    else $error("frame count above limit");

  // The bypass is only armed for an item in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> exec_q)
    else $error("bypass armed without an item");

  // An item held by a full output stays in work and leaves the state alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_q && m_valid_q && !m_axis_tready) |=>
      (exec_q && $stable(top_q) && $stable(frames_q)))
    else $error("item lost or state moved while output held");

  // A successful allocate always leaves one more frame open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_done && mem_we) |=> (frames_q == $past(frames_q) + FrameW'(1)))
    else $error("allocate did not open a frame");

endmodule

`default_nettype wire
